// ===== design/mstt_pkg.sv =====
// Shared types and constants for the multi-slot tick timer.
// No dependencies; imported by mstt_alloc and multi_slot_tick_timer.
`timescale 1ns / 1ps

package mstt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int STEP_W      = SLOT_W + 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_CREATED   = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_REMOVED   = 3'd2,
    KIND_EXPIRED   = 3'd3,
    KIND_IDLE_TICK = 3'd4
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] period;
    logic        periodic;
    logic [3:0]  slot_id;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] slot;
    logic       is_last;
  } result_t;

  // One slot as stored in the timer memory.
  typedef struct packed {
    logic        rpt;
    logic [31:0] reload;
    logic [31:0] remaining;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/mstt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mstt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mstt_alloc.sv =====
// Lowest-free-slot finder over the slot activity bits.
// Depends on mstt_pkg.
`timescale 1ns / 1ps

module mstt_alloc (
  input  logic [mstt_pkg::NUM_SLOTS-1:0] active,
  output logic                           found,
  output logic [mstt_pkg::SLOT_W-1:0]    free_idx
);

  import mstt_pkg::*;

  // Scan from the top so the lowest free slot wins.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        found    = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

endmodule

// ===== design/multi_slot_tick_timer.sv =====
// Top level of the multi-slot tick timer: command decode, tick scan sequencer,
// slot activity bits and result register.
// Depends on mstt_pkg, mstt_ram and mstt_alloc.
`timescale 1ns / 1ps

// Channel   | Ports                     | Transfer
// ----------+---------------------------+---------------------------------------
// command   | start, busy, item         | rising edge with start high, busy low
// result    | result_strobe, result     | every cycle result_strobe is high
//
// Create and remove finish in the cycle of the transfer; their result shows
// in the following cycle and busy stays low, so commands may follow back to back.
// A tick scans every slot through the timer memory, one slot per cycle, and
// holds busy high through the scan and flush; the read port delays the scan.
// Synchronous active-high reset frees all slots; memory contents need no
// clearing since the scan ignores a free slot's entry until create rewrites it.
// The receiver cannot stall; each result is presented for one cycle only.

module multi_slot_tick_timer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mstt_pkg::cmd_t    item,
  output logic              result_strobe,
  output mstt_pkg::result_t result
);

  import mstt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t                state;
  logic [STEP_W-1:0]     step;
  logic [NUM_SLOTS-1:0]  active;
  logic                  hold_vld;
  logic [SLOT_W-1:0]     hold_idx;
  logic [CNT_W-1:0]      n_rep;

  logic                  accept;
  logic                  found;
  logic [SLOT_W-1:0]     free_idx;
  logic [31:0]           period_arm;
  logic                  rm_in_range;
  logic [SLOT_W-1:0]     rm_idx;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  entry_t                ram_wdata;
  entry_t                rd_entry;

  logic                  proc;
  logic [SLOT_W-1:0]     proc_idx;
  logic                  slot_act;
  logic [31:0]           rem_dec;
  logic [31:0]           rem_next;
  logic                  hits;
  logic                  take;
  logic                  last_step;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  mstt_alloc u_alloc (
    .active   (active),
    .found    (found),
    .free_idx (free_idx)
  );

  // Zero period arms as one tick.
  assign period_arm  = (item.period == 32'd0) ? 32'd1 : item.period;
  assign rm_in_range = ({4'd0, item.slot_id} < 8'(NUM_SLOTS));
  assign rm_idx      = SLOT_W'(item.slot_id);

  // Step k reads slot k and processes slot k-1 returned by the memory.
  assign proc      = (state == ST_SCAN) && (step != '0);
  assign proc_idx  = SLOT_W'(step - STEP_W'(1));
  assign last_step = (step == STEP_W'(NUM_SLOTS));
  assign slot_act  = active[proc_idx];
  assign rem_dec   = (rd_entry.remaining == 32'd0) ? 32'd0 : rd_entry.remaining - 32'd1;
  assign hits      = proc && slot_act && (rd_entry.remaining <= 32'd1);
  assign take      = hits && (n_rep < CNT_W'(MAX_RESULTS));

  always_comb begin
    rem_next = rem_dec;
    if (hits && rd_entry.rpt) begin
      rem_next = (rd_entry.reload == 32'd0) ? 32'd1 : rd_entry.reload;
    end
  end

  // Write port: create arms the new slot; the scan writes back the countdown.
  always_comb begin
    if (state == ST_IDLE) begin
      ram_we    = accept && (item.op == OP_CREATE) && found;
      ram_waddr = free_idx;
      ram_wdata = '{rpt: item.periodic, reload: period_arm, remaining: period_arm};
    end else begin
      ram_we    = proc && slot_act;
      ram_waddr = proc_idx;
      ram_wdata = '{rpt: rd_entry.rpt, reload: rd_entry.reload, remaining: rem_next};
    end
  end

  mstt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (step[SLOT_W-1:0]),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      active        <= '0;
      hold_vld      <= 1'b0;
      hold_idx      <= '0;
      n_rep         <= '0;
      result_strobe <= 1'b0;
      result        <= '{kind: KIND_IDLE_TICK, slot: 4'd0, is_last: 1'b0};
    end else begin
      case (state)
        ST_IDLE: begin
          // Create and remove report at once; a tick reports from the scan.
          result_strobe <= accept && (item.op inside {OP_CREATE, OP_REMOVE});
          if (accept) begin
            case (item.op)
              OP_CREATE: begin
                if (found) begin
                  active[free_idx] <= 1'b1;
                  result <= '{kind: KIND_CREATED, slot: 4'(free_idx), is_last: 1'b1};
                end else begin
                  result <= '{kind: KIND_FULL, slot: 4'd0, is_last: 1'b1};
                end
              end
              OP_REMOVE: begin
                if (rm_in_range) begin
                  active[rm_idx] <= 1'b0;
                end
                result <= '{kind: KIND_REMOVED, slot: item.slot_id, is_last: 1'b1};
              end
              OP_TICK: begin
                state    <= ST_SCAN;
                step     <= '0;
                hold_vld <= 1'b0;
                n_rep    <= '0;
              end
              default: begin
                // Unused opcode: drop it, no result.
              end
            endcase
          end
        end

        ST_SCAN: begin
          step <= step + STEP_W'(1);
          // Release the previously held expiry when a new one arrives.
          result_strobe <= take && hold_vld;
          // Free a one-shot slot on expiry.
          if (hits && !rd_entry.rpt) begin
            active[proc_idx] <= 1'b0;
          end
          // Hold the newest expiry back one place so the final one can be
          // flagged last; release the previously held one now.
          if (take) begin
            if (hold_vld) begin
              result <= '{kind: KIND_EXPIRED, slot: 4'(hold_idx), is_last: 1'b0};
            end
            hold_vld <= 1'b1;
            hold_idx <= proc_idx;
            n_rep    <= n_rep + CNT_W'(1);
          end
          if (last_step) begin
            state <= ST_FLUSH;
          end
        end

        ST_FLUSH: begin
          result_strobe <= 1'b1;
          if (hold_vld) begin
            result <= '{kind: KIND_EXPIRED, slot: 4'(hold_idx), is_last: 1'b1};
          end else begin
            result <= '{kind: KIND_IDLE_TICK, slot: 4'd0, is_last: 1'b1};
          end
          hold_vld <= 1'b0;
          state    <= ST_IDLE;
        end

        default: begin
          result_strobe <= 1'b0;
          state         <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
